// ===== hw/rtl/qdec_pkg.sv =====
`timescale 1ns / 1ps
// qdec_pkg: shared types and constants for the quadrature decoder with speed
// no dependencies; used by the channel interfaces and the top level
package qdec_pkg;

    localparam int SPEED_WIDTH     = 32;
    localparam int POS_OUT_WIDTH   = 32;
    localparam int TIMEOUT_WIDTH   = 24;
    localparam int CFG_INDEX_WIDTH = 4;
    localparam int CFG_DATA_WIDTH  = 32;

    typedef logic [1:0]                 t_pair;
    typedef logic [3:0]                 t_step_sel;
    typedef logic [CFG_INDEX_WIDTH-1:0] t_cfg_index;

    // step tables indexed by {old pair, new pair}
    localparam logic [15:0] DOWN_STEPS = 16'h2814;
    localparam logic [15:0] UP_STEPS   = 16'h4182;

    // configuration register indexes
    localparam t_cfg_index REG_SPEED_NUM    = t_cfg_index'(0);
    localparam t_cfg_index REG_STOP_TIMEOUT = t_cfg_index'(1);

    // configuration reset values
    localparam logic [SPEED_WIDTH-1:0]   SPEED_NUM_RESET = 32'd1000000;
    localparam logic [TIMEOUT_WIDTH-1:0] TIMEOUT_RESET   = 24'd10000;

endpackage

// ===== hw/rtl/qdec_if.sv =====
`timescale 1ns / 1ps
// qdec channel interfaces: sample input, result output and register write port
// depends on qdec_pkg for field widths
interface qdec_in_if;
    logic valid;
    logic ready;
    logic pin_a;
    logic pin_b;
    logic clear_count;

    modport source (output valid, output pin_a, output pin_b, output clear_count,
                    input ready);
    modport sink   (input valid, input pin_a, input pin_b, input clear_count,
                    output ready);
endinterface

interface qdec_out_if;
    logic                                   valid;
    logic                                   ready;
    logic signed [qdec_pkg::POS_OUT_WIDTH-1:0] position_count;
    logic [qdec_pkg::SPEED_WIDTH-1:0]       speed;
    logic                                   stopped;

    modport source (output valid, output position_count, output speed, output stopped,
                    input ready);
    modport sink   (input valid, input position_count, input speed, input stopped,
                    output ready);
endinterface

interface qdec_cfg_if;
    logic                                  valid;
    logic                                  ready;
    logic [qdec_pkg::CFG_INDEX_WIDTH-1:0]  index;
    logic [qdec_pkg::CFG_DATA_WIDTH-1:0]   data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== hw/rtl/qdec_div.sv =====
`timescale 1ns / 1ps
// qdec_div: bit-serial restoring divider, one quotient bit per cycle
// no package dependencies; instantiated by quadrature_decoder_with_speed
module qdec_div #(
    parameter int NUM_WIDTH = 32,
    parameter int DIV_WIDTH = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [NUM_WIDTH-1:0] i_numerator,
    input  logic [DIV_WIDTH-1:0] i_divisor,
    output logic                 o_last,
    output logic [NUM_WIDTH-1:0] o_quotient
);

    localparam int CNT_W = (NUM_WIDTH > 1) ? $clog2(NUM_WIDTH) : 1;
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(NUM_WIDTH - 1);

    logic                 r_busy;
    logic [CNT_W-1:0]     r_cnt;
    logic [DIV_WIDTH-1:0] r_rem;
    logic [DIV_WIDTH-1:0] r_div;
    // numerator bits shift out at the top while quotient bits shift in at the bottom
    logic [NUM_WIDTH-1:0] r_quo;

    logic [DIV_WIDTH:0]   n_trial;
    logic [DIV_WIDTH:0]   n_diff;
    logic                 n_ge;
    logic [DIV_WIDTH-1:0] n_rem;

    // one trial subtraction per cycle
    always_comb begin
        n_trial = {r_rem, r_quo[NUM_WIDTH-1]};
        n_diff  = n_trial - {1'b0, r_div};
        n_ge    = n_trial >= {1'b0, r_div};
        n_rem   = n_ge ? n_diff[DIV_WIDTH-1:0] : n_trial[DIV_WIDTH-1:0];
    end

    // iteration control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + CNT_W'(1);
            if (r_cnt == CNT_LAST) begin
                r_busy <= 1'b0;
            end
        end
    end

    // datapath shift registers
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_div <= i_divisor;
            r_quo <= i_numerator;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= {r_quo[NUM_WIDTH-2:0], n_ge};
        end
    end

    assign o_last     = r_busy && (r_cnt == CNT_LAST);
    assign o_quotient = r_quo;

endmodule

// ===== hw/rtl/quadrature_decoder_with_speed.sv =====
`timescale 1ns / 1ps
// 4x quadrature decoder with signed position count and tick-period speed
// depends on qdec_pkg, qdec_if and qdec_div
// a sample whose speed is computed passes from its transfer to the divide state, where the
//   bit-serial divider produces one quotient bit per cycle, and on to the done state
// a stopped sample skips the divider and goes from its transfer straight to the done state
// the done state waits for a free output register; new samples are taken only in idle
// synchronous active-low reset clears count, timers and pin history, loads register defaults
module quadrature_decoder_with_speed #(
    parameter int COUNT_WIDTH = 32,
    parameter int TIME_WIDTH  = 32
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    qdec_cfg_if.sink      i_cfg,
    qdec_in_if.sink       i_in,
    qdec_out_if.source    o_res
);
    import qdec_pkg::*;

    localparam int CMP_W = (TIME_WIDTH > TIMEOUT_WIDTH) ? TIME_WIDTH : TIMEOUT_WIDTH;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [1:0]               r_state;
    logic [SPEED_WIDTH-1:0]   r_speed_num;
    logic [TIMEOUT_WIDTH-1:0] r_timeout;
    t_pair                    r_last_pair;
    logic [COUNT_WIDTH-1:0]   r_position;
    logic [TIME_WIDTH-1:0]    r_since;
    logic [TIME_WIDTH-1:0]    r_period;
    logic                     r_stop;

    logic                     r_out_valid;
    logic [POS_OUT_WIDTH-1:0] r_out_pos;
    logic [SPEED_WIDTH-1:0]   r_out_speed;
    logic                     r_out_stop;

    t_pair                    n_pair;
    t_step_sel                n_sel;
    logic [COUNT_WIDTH-1:0]   n_pos_base;
    logic [COUNT_WIDTH-1:0]   n_position;
    logic [TIME_WIDTH-1:0]    n_since_inc;
    logic [TIME_WIDTH-1:0]    n_since;
    logic [TIME_WIDTH-1:0]    n_period;
    logic                     n_tick;
    logic                     n_stop;

    logic                     w_in_xfer;
    logic                     w_out_free;
    logic                     w_div_last;
    logic [SPEED_WIDTH-1:0]   w_quotient;

    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = (r_state == ST_IDLE);
    assign w_in_xfer   = i_in.valid && i_in.ready;
    assign w_out_free  = !r_out_valid || o_res.ready;

    // decode of the incoming sample against the stored state
    always_comb begin
        n_pair      = {i_in.pin_a, i_in.pin_b};
        n_sel       = {r_last_pair, n_pair};
        n_pos_base  = i_in.clear_count ? '0 : r_position;
        n_since_inc = (r_since == '1) ? r_since : r_since + TIME_WIDTH'(1);
        n_tick      = (n_pair != r_last_pair);
        if (DOWN_STEPS[n_sel]) begin
            n_position = n_pos_base - COUNT_WIDTH'(1);
        end else if (UP_STEPS[n_sel]) begin
            n_position = n_pos_base + COUNT_WIDTH'(1);
        end else begin
            n_position = n_pos_base;
        end
        n_period = n_tick ? n_since_inc : r_period;
        n_since  = n_tick ? '0 : n_since_inc;
        n_stop   = (CMP_W'(n_since) > CMP_W'(r_timeout)) || (n_period == '0);
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_speed_num <= SPEED_NUM_RESET;
            r_timeout   <= TIMEOUT_RESET;
        end else if (i_cfg.valid && i_cfg.ready) begin
            case (i_cfg.index)
                REG_SPEED_NUM:    r_speed_num <= i_cfg.data[SPEED_WIDTH-1:0];
                REG_STOP_TIMEOUT: r_timeout   <= i_cfg.data[TIMEOUT_WIDTH-1:0];
                default: ;
            endcase
        end
    end

    // decoder state, updated on each sample transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_pair <= '0;
            r_position  <= '0;
            r_since     <= '0;
            r_period    <= '0;
            r_stop      <= 1'b0;
        end else if (w_in_xfer) begin
            r_last_pair <= n_pair;
            r_position  <= n_position;
            r_since     <= n_since;
            r_period    <= n_period;
            r_stop      <= n_stop;
        end
    end

    // sequencer: idle, dividing, waiting for the output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (w_in_xfer) begin
                        r_state <= n_stop ? ST_DONE : ST_DIV;
                    end
                end
                ST_DIV: begin
                    if (w_div_last) begin
                        r_state <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (w_out_free) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // speed divider
    qdec_div #(
        .NUM_WIDTH (SPEED_WIDTH),
        .DIV_WIDTH (TIME_WIDTH)
    ) u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (w_in_xfer && !n_stop),
        .i_numerator (r_speed_num),
        .i_divisor   (n_period),
        .o_last      (w_div_last),
        .o_quotient  (w_quotient)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == ST_DONE) && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == ST_DONE) && w_out_free) begin
            r_out_pos   <= POS_OUT_WIDTH'(r_position);
            r_out_speed <= r_stop ? '0 : w_quotient;
            r_out_stop  <= r_stop;
        end
    end

    assign o_res.valid          = r_out_valid;
    assign o_res.position_count = $signed(r_out_pos);
    assign o_res.speed          = r_out_speed;
    assign o_res.stopped        = r_out_stop;

    // a stopped result always carries zero speed
    a_stop_zero_speed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && o_res.stopped |-> o_res.speed == '0)
        else $error("stopped result with nonzero speed");

    // the divider never runs on a zero period
    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_DIV |-> r_period != '0)
        else $error("division by zero period");

    // the last divider step only happens while dividing
    a_div_last_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_last |-> r_state == ST_DIV)
        else $error("divider finished outside divide state");

    // a sample transfer always leaves idle
    a_xfer_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_xfer |=> r_state != ST_IDLE)
        else $error("sample transfer did not start work");

endmodule
